>>> rtl/ehc_pkg.sv
package ehc_pkg;

    // Parameter defaults
    localparam int MaxParamBytesDef    = 248;
    localparam int MaxResponseBytesDef = 248;
    localparam logic [15:0] RetryLimitReset = 16'd10000;

    // I/O map
    localparam logic [11:0] ADDR_DATA   = 12'h200;
    localparam logic [11:0] ADDR_CMD    = 12'h204;
    localparam logic [11:0] ADDR_PACKET = 12'h800;
    localparam logic [11:0] ADDR_PARAM  = 12'h808;
    localparam logic [7:0]  PROTO3_CMD  = 8'hda;
    localparam logic [7:0]  BUSY_MASK   = 8'h06;
    localparam logic [7:0]  REQ_VERSION = 8'h03;
    localparam int          HdrBytes    = 8;

    // input kinds
    localparam logic [1:0] IN_START = 2'd0;
    localparam logic [1:0] IN_PARAM = 2'd1;
    localparam logic [1:0] IN_RDATA = 2'd2;

    // result kinds
    localparam logic [1:0] RK_BUS  = 2'd0;
    localparam logic [1:0] RK_DATA = 2'd1;
    localparam logic [1:0] RK_DONE = 2'd2;

    // completion status
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TIMEOUT  = 3'd1;
    localparam logic [2:0] ST_RESULT   = 3'd2;
    localparam logic [2:0] ST_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] command_code;
        logic [7:0]  cmd_version;
        logic [7:0]  param_count;
        logic [7:0]  data_byte;
    } ehc_in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        bus_is_write;
        logic [11:0] bus_address;
        logic [7:0]  bus_write_data;
        logic [7:0]  response_byte;
        logic [2:0]  status_code;
        logic [15:0] controller_result;
    } ehc_beat_t;

    // One input's worth of output: optional lead beat, optional request
    // header sequence (8 header writes, command write, first poll), optional
    // tail beat.
    typedef struct packed {
        logic        lead_valid;
        ehc_beat_t   lead;
        logic        hdr_valid;
        logic [15:0] hdr_cmd;
        logic [7:0]  hdr_ver;
        logic [7:0]  hdr_len;
        logic [7:0]  hdr_chk;
        logic        tail_valid;
        ehc_beat_t   tail;
    } ehc_desc_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ehc_seq_stat_t;

endpackage

>>> rtl/ehc_ctrl.sv
module ehc_ctrl import ehc_pkg::*; #(
    parameter int MAX_PARAM_BYTES    = MaxParamBytesDef,
    parameter int MAX_RESPONSE_BYTES = MaxResponseBytesDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        proc_fire,
    input  ehc_in_t     item,
    input  logic [15:0] retry_limit,
    output ehc_desc_t   desc
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_PARAMS = 3'd1;
    localparam logic [2:0] PH_POLL   = 3'd2;
    localparam logic [2:0] PH_RESULT = 3'd3;
    localparam logic [2:0] PH_HEADER = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;

    localparam logic [7:0]  MaxParam = 8'(MAX_PARAM_BYTES);
    localparam logic [15:0] MaxResp  = 16'(MAX_RESPONSE_BYTES);

    logic [2:0]  phase_reg,            phase_next;
    logic [7:0]  param_index_reg,      param_index_next;
    logic [7:0]  param_total_reg,      param_total_next;
    logic [7:0]  running_sum_reg,      running_sum_next;
    logic [15:0] saved_command_reg,    saved_command_next;
    logic [7:0]  saved_version_reg,    saved_version_next;
    logic [15:0] polls_left_reg,       polls_left_next;
    logic [7:0]  reply_index_reg,      reply_index_next;
    logic [15:0] reply_result_reg,     reply_result_next;
    logic [15:0] reply_length_reg,     reply_length_next;
    logic [7:0]  pending_low_byte_reg, pending_low_byte_next;

    function automatic ehc_beat_t bus_beat(input logic wr, input logic [11:0] addr,
                                           input logic [7:0] wdata);
        ehc_beat_t b;
        b = '0;
        b.result_kind    = RK_BUS;
        b.bus_is_write   = wr;
        b.bus_address    = addr;
        b.bus_write_data = wdata;
        return b;
    endfunction

    function automatic ehc_beat_t done_beat(input logic [2:0] st, input logic [15:0] cres);
        ehc_beat_t b;
        b = '0;
        b.result_kind       = RK_DONE;
        b.status_code       = st;
        b.controller_result = cres;
        return b;
    endfunction

    logic [7:0]  clipped_cnt;
    logic [7:0]  hdr_sum_base;
    logic [7:0]  hdr_sum;
    logic [15:0] hdr_cmd;
    logic [7:0]  hdr_ver;
    logic [7:0]  hdr_len;
    logic        start_hdr;
    logic [7:0]  b;
    logic [7:0]  sum_b;
    logic [7:0]  idx_inc;
    logic [7:0]  ridx_inc;
    logic [15:0] poll_load;

    assign b         = item.data_byte;
    assign sum_b     = running_sum_reg + b;
    assign idx_inc   = param_index_reg + 8'd1;
    assign ridx_inc  = reply_index_reg + 8'd1;
    assign poll_load = (retry_limit == 16'd0) ? 16'd1 : retry_limit;
    assign clipped_cnt = (item.param_count > MaxParam) ? MaxParam : item.param_count;

    // Header contents come straight from the item on a zero-length start.
    assign hdr_cmd      = (item.kind == IN_START) ? item.command_code : saved_command_reg;
    assign hdr_ver      = (item.kind == IN_START) ? item.cmd_version : saved_version_reg;
    assign hdr_len      = (item.kind == IN_START) ? 8'd0 : param_total_reg;
    assign hdr_sum_base = (item.kind == IN_START) ? 8'd0 : sum_b;
    assign hdr_sum      = hdr_sum_base + REQ_VERSION + hdr_cmd[7:0] + hdr_cmd[15:8]
                        + hdr_ver + hdr_len;

    always_comb begin
        phase_next            = phase_reg;
        param_index_next      = param_index_reg;
        param_total_next      = param_total_reg;
        running_sum_next      = running_sum_reg;
        saved_command_next    = saved_command_reg;
        saved_version_next    = saved_version_reg;
        polls_left_next       = polls_left_reg;
        reply_index_next      = reply_index_reg;
        reply_result_next     = reply_result_reg;
        reply_length_next     = reply_length_reg;
        pending_low_byte_next = pending_low_byte_reg;
        start_hdr             = 1'b0;
        desc                  = '0;

        unique case (item.kind)
            IN_START: begin
                saved_command_next = item.command_code;
                saved_version_next = item.cmd_version;
                param_total_next   = clipped_cnt;
                param_index_next   = 8'd0;
                running_sum_next   = 8'd0;
                if (clipped_cnt == 8'd0) begin
                    start_hdr = 1'b1;
                end else begin
                    phase_next = PH_PARAMS;
                end
            end
            IN_PARAM: begin
                if (phase_reg == PH_PARAMS) begin
                    desc.lead_valid  = 1'b1;
                    desc.lead        = bus_beat(1'b1, ADDR_PARAM + {4'd0, param_index_reg}, b);
                    running_sum_next = sum_b;
                    param_index_next = idx_inc;
                    if (idx_inc >= param_total_reg) begin
                        start_hdr = 1'b1;
                    end
                end
            end
            IN_RDATA: begin
                unique case (phase_reg)
                    PH_POLL: begin
                        desc.lead_valid = 1'b1;
                        if ((b & BUSY_MASK) == 8'd0) begin
                            phase_next = PH_RESULT;
                            desc.lead  = bus_beat(1'b0, ADDR_DATA, 8'd0);
                        end else if (polls_left_reg <= 16'd1) begin
                            polls_left_next = 16'd0;
                            phase_next      = PH_IDLE;
                            desc.lead       = done_beat(ST_TIMEOUT, 16'd0);
                        end else begin
                            polls_left_next = polls_left_reg - 16'd1;
                            desc.lead       = bus_beat(1'b0, ADDR_CMD, 8'd0);
                        end
                    end
                    PH_RESULT: begin
                        desc.lead_valid = 1'b1;
                        if (b != 8'd0) begin
                            phase_next = PH_IDLE;
                            desc.lead  = done_beat(ST_RESULT, {8'd0, b});
                        end else begin
                            phase_next       = PH_HEADER;
                            reply_index_next = 8'd0;
                            running_sum_next = 8'd0;
                            desc.lead        = bus_beat(1'b0, ADDR_PACKET, 8'd0);
                        end
                    end
                    PH_HEADER: begin
                        desc.lead_valid  = 1'b1;
                        running_sum_next = sum_b;
                        reply_index_next = ridx_inc;
                        if (reply_index_reg == 8'd2 || reply_index_reg == 8'd4) begin
                            pending_low_byte_next = b;
                        end else if (reply_index_reg == 8'd3) begin
                            reply_result_next = {b, pending_low_byte_reg};
                        end else if (reply_index_reg == 8'd5) begin
                            reply_length_next = {b, pending_low_byte_reg};
                        end
                        if (ridx_inc < 8'(HdrBytes)) begin
                            desc.lead = bus_beat(1'b0, ADDR_PACKET + {4'd0, ridx_inc}, 8'd0);
                        end else if (reply_length_next > MaxResp) begin
                            phase_next = PH_IDLE;
                            desc.lead  = done_beat(ST_TOO_LONG, reply_result_next);
                        end else begin
                            reply_index_next = 8'd0;
                            if (reply_length_next == 16'd0) begin
                                phase_next = PH_IDLE;
                                desc.lead  = done_beat((sum_b == 8'd0) ? ST_OK : ST_CHECKSUM,
                                                       reply_result_next);
                            end else begin
                                phase_next = PH_DATA;
                                desc.lead  = bus_beat(1'b0, ADDR_PARAM, 8'd0);
                            end
                        end
                    end
                    PH_DATA: begin
                        desc.lead_valid         = 1'b1;
                        desc.lead               = '0;
                        desc.lead.result_kind   = RK_DATA;
                        desc.lead.response_byte = b;
                        desc.tail_valid         = 1'b1;
                        running_sum_next        = sum_b;
                        reply_index_next        = ridx_inc;
                        if ({8'd0, ridx_inc} >= reply_length_reg) begin
                            phase_next = PH_IDLE;
                            desc.tail  = done_beat((sum_b == 8'd0) ? ST_OK : ST_CHECKSUM,
                                                   reply_result_reg);
                        end else begin
                            desc.tail = bus_beat(1'b0, ADDR_PARAM + {4'd0, ridx_inc}, 8'd0);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        if (start_hdr) begin
            desc.hdr_valid  = 1'b1;
            desc.hdr_cmd    = hdr_cmd;
            desc.hdr_ver    = hdr_ver;
            desc.hdr_len    = hdr_len;
            desc.hdr_chk    = 8'd0 - hdr_sum;
            polls_left_next = poll_load;
            phase_next      = PH_POLL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg            <= PH_IDLE;
            param_index_reg      <= '0;
            param_total_reg      <= '0;
            running_sum_reg      <= '0;
            saved_command_reg    <= '0;
            saved_version_reg    <= '0;
            polls_left_reg       <= '0;
            reply_index_reg      <= '0;
            reply_result_reg     <= '0;
            reply_length_reg     <= '0;
            pending_low_byte_reg <= '0;
        end else if (proc_fire) begin
            phase_reg            <= phase_next;
            param_index_reg      <= param_index_next;
            param_total_reg      <= param_total_next;
            running_sum_reg      <= running_sum_next;
            saved_command_reg    <= saved_command_next;
            saved_version_reg    <= saved_version_next;
            polls_left_reg       <= polls_left_next;
            reply_index_reg      <= reply_index_next;
            reply_result_reg     <= reply_result_next;
            reply_length_reg     <= reply_length_next;
            pending_low_byte_reg <= pending_low_byte_next;
        end
    end

    // polling always has at least one poll in hand
    a_poll_budget: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_POLL |-> polls_left_reg != 16'd0)
        else $error("poll phase with no polls left");

    a_param_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PARAMS |-> param_index_reg < param_total_reg)
        else $error("parameter index past count");

    a_hdr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HEADER |-> reply_index_reg < 8'(HdrBytes))
        else $error("response header index out of range");

endmodule

>>> rtl/ehc_beat_seq.sv
module ehc_beat_seq import ehc_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  ehc_desc_t     desc,
    output ehc_seq_stat_t stat,
    output logic          m_tvalid,
    input  logic          m_tready,
    output ehc_beat_t     beat,
    output logic          m_tlast
);

    // position codes: lead beat, header steps, tail beat
    localparam logic [3:0] POS_LEAD     = 4'd0;
    localparam logic [3:0] POS_HDR0     = 4'd1;
    localparam logic [3:0] POS_HDR_LAST = 4'd10;
    localparam logic [3:0] POS_TAIL     = 4'd11;

    ehc_desc_t  desc_reg;
    logic       busy_reg, busy_next;
    logic [3:0] pos_reg,  pos_next;
    logic [3:0] hstep;
    logic [3:0] load_pos;
    logic       take;

    always_comb begin
        hstep = pos_reg - POS_HDR0;
        beat  = '0;
        if (pos_reg == POS_LEAD) begin
            beat = desc_reg.lead;
        end else if (pos_reg == POS_TAIL) begin
            beat = desc_reg.tail;
        end else begin
            beat.result_kind  = RK_BUS;
            beat.bus_is_write = 1'b1;
            if (hstep < 4'(HdrBytes)) begin
                beat.bus_address = ADDR_PACKET + {8'd0, hstep};
                unique case (hstep[2:0])
                    3'd0:    beat.bus_write_data = REQ_VERSION;
                    3'd1:    beat.bus_write_data = desc_reg.hdr_chk;
                    3'd2:    beat.bus_write_data = desc_reg.hdr_cmd[7:0];
                    3'd3:    beat.bus_write_data = desc_reg.hdr_cmd[15:8];
                    3'd4:    beat.bus_write_data = desc_reg.hdr_ver;
                    3'd6:    beat.bus_write_data = desc_reg.hdr_len;
                    default: beat.bus_write_data = 8'd0;
                endcase
            end else if (hstep == 4'(HdrBytes)) begin
                beat.bus_address    = ADDR_CMD;
                beat.bus_write_data = PROTO3_CMD;
            end else begin
                beat.bus_is_write = 1'b0;
                beat.bus_address  = ADDR_CMD;
            end
        end
    end

    always_comb begin
        priority if (pos_reg == POS_LEAD) begin
            m_tlast = !desc_reg.hdr_valid && !desc_reg.tail_valid;
        end else if (pos_reg == POS_TAIL) begin
            m_tlast = 1'b1;
        end else begin
            m_tlast = (pos_reg == POS_HDR_LAST) && !desc_reg.tail_valid;
        end
    end

    assign m_tvalid  = busy_reg;
    assign take      = busy_reg && m_tready;
    assign stat.busy = busy_reg;
    assign stat.done = take && m_tlast;

    assign load_pos = desc.lead_valid ? POS_LEAD : (desc.hdr_valid ? POS_HDR0 : POS_TAIL);

    always_comb begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (take) begin
            if (m_tlast) begin
                busy_next = 1'b0;
            end else if (pos_reg == POS_LEAD) begin
                pos_next = desc_reg.hdr_valid ? POS_HDR0 : POS_TAIL;
            end else if (pos_reg == POS_HDR_LAST) begin
                pos_next = POS_TAIL;
            end else begin
                pos_next = pos_reg + 4'd1;
            end
        end
        if (load && (desc.lead_valid || desc.hdr_valid || desc.tail_valid)) begin
            busy_next = 1'b1;
            pos_next  = load_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= POS_LEAD;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            desc_reg <= desc;
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> !busy_reg || stat.done)
        else $error("burst loaded over an unfinished one");

    a_tail_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && pos_reg == POS_TAIL |-> desc_reg.tail_valid)
        else $error("tail position without tail beat");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> pos_reg <= POS_TAIL)
        else $error("beat position out of range");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !m_tready |=> $stable(pos_reg) && busy_reg)
        else $error("burst advanced while stalled");

endmodule

>>> rtl/ec_host_command_packet_engine.sv
// Host-command packet engine (protocol v3). Input beats on s_: a start beat
// (tuser 0) with command, version and parameter count, then that many
// parameter beats (tuser 1), then each bus read reply (tuser 2) as the bus
// delivers it. Each input beat yields 0 to 11 output beats on m_: bus access
// requests (tuser 0), response payload bytes (tuser 1) and one completion
// (tuser 2) with a status code; tlast marks the final beat produced by one
// input beat. The engine accepts one input beat per cycle as long as the
// output side keeps up; a beat with a multi-beat burst holds the input until
// the single output burst register has sent it all (the last parameter byte
// also triggers the 8-byte header, command write and first status poll).
// Accepted beats pass the input register, then the burst register. The user
// must write poll_retry_limit through cfg_wr_en / cfg_wr_data only while the
// engine is quiet, not enforced by the block; zero behaves as one.
module ec_host_command_packet_engine import ehc_pkg::*; #(
    parameter int MAX_PARAM_BYTES    = MaxParamBytesDef,
    parameter int MAX_RESPONSE_BYTES = MaxResponseBytesDef
) (
    input  logic        aclk,
    input  logic        aresetn,

    // config: poll_retry_limit
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // command_code[15:0], cmd_version[23:16],
                                   // param_count[31:24], data_byte[39:32]
    input  logic [1:0]  s_tuser,   // kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // bus_is_write[0], bus_address[12:1],
                                   // bus_write_data[20:13], response_byte[28:21],
                                   // status_code[31:29], controller_result[47:32]
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast    // last_of_run
);

    // input register
    logic          in_valid_reg;
    ehc_in_t       in_reg;
    logic          proc_fire;

    logic [15:0]   retry_limit_reg;

    ehc_desc_t     desc;
    ehc_seq_stat_t seq_stat;
    ehc_beat_t     beat;

    // An item is processed once the burst register is free or emptying now.
    assign proc_fire = in_valid_reg && (!seq_stat.busy || seq_stat.done);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.kind         <= s_tuser;
            in_reg.command_code <= s_tdata[15:0];
            in_reg.cmd_version  <= s_tdata[23:16];
            in_reg.param_count  <= s_tdata[31:24];
            in_reg.data_byte    <= s_tdata[39:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_limit_reg <= RetryLimitReset;
        end else if (cfg_wr_en) begin
            retry_limit_reg <= cfg_wr_data;
        end
    end

    // protocol state and burst planning
    ehc_ctrl #(
        .MAX_PARAM_BYTES    (MAX_PARAM_BYTES),
        .MAX_RESPONSE_BYTES (MAX_RESPONSE_BYTES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .proc_fire   (proc_fire),
        .item        (in_reg),
        .retry_limit (retry_limit_reg),
        .desc        (desc)
    );

    // burst register, one output beat per cycle while m_tready is high
    ehc_beat_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (proc_fire),
        .desc     (desc),
        .stat     (seq_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .beat     (beat),
        .m_tlast  (m_tlast)
    );

    assign m_tuser = beat.result_kind;
    assign m_tdata = {beat.controller_result, beat.status_code, beat.response_byte,
                      beat.bus_write_data, beat.bus_address, beat.bus_is_write};

endmodule
